FILE: src/gbp_pkg.sv
// Shared types, constants and register codes of the gshare branch predictor.
`timescale 1ns / 1ps

package gbp_pkg;

  // Table geometry and field widths
  localparam int INDEX_BITS = 12;
  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 32;
  localparam int HIST_CFG_W = 4;
  localparam int CTR_W      = 2;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  // Reset values
  localparam logic [CTR_W-1:0]      CTR_RESET  = 2'd2;
  localparam logic [HIST_CFG_W-1:0] HIST_RESET = 4'd8;
  localparam logic [CNT_W-1:0]      CNT_MAX    = '1;

  // Register index decoded from paddr[2]
  localparam logic REG_HISTORY_BITS = 1'b0;

  // Input word: one branch
  typedef struct packed {
    logic [ADDR_W-1:0] branch_address;
    logic              taken;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic             predicted_taken;
    logic             mispredicted;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] branch_total;
  } out_word_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_en;  // write reset value at the sweep pointer
    logic rd_en;   // take the input word and read the table
    logic upd_en;  // write back counter, update history, load result
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;  // sweep pointer at the last entry
    logic out_free;  // result register can take a word this cycle
  } dp_stat_t;

endpackage

FILE: src/gbp_if.sv
// Valid/ready channel interfaces for branch words and result words.
`timescale 1ns / 1ps

interface gbp_in_if;
  logic             valid;
  logic             ready;
  gbp_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gbp_out_if;
  logic              valid;
  logic              ready;
  gbp_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/gbp_ctrl.sv
// Controller: table clearing sweep, branch read and read-modify-write sequencing.
`timescale 1ns / 1ps

module gbp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gbp_pkg::dp_stat_t    stat,
  output gbp_pkg::ctrl_cmd_t   cmd
);

  gbp_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbp_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbp_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_nxt = gbp_pkg::ST_IDLE;
      end
      gbp_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = gbp_pkg::ST_UPDATE;
      end
      gbp_pkg::ST_UPDATE: begin
        if (stat.out_free) state_nxt = gbp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gbp_pkg::ST_CLEAR;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      gbp_pkg::ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      gbp_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.rd_en  = in_valid;
      end
      gbp_pkg::ST_UPDATE: begin
        cmd.upd_en = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: src/gbp_dp.sv
// Datapath: counter table, global history, totals and result register.
`timescale 1ns / 1ps

module gbp_dp #(
  parameter int INDEX_BITS = gbp_pkg::INDEX_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gbp_pkg::ctrl_cmd_t                  cmd,
  output gbp_pkg::dp_stat_t                   stat,
  input  logic [gbp_pkg::HIST_CFG_W-1:0]      hist_bits,
  input  gbp_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gbp_pkg::out_word_t                  out_data
);

  localparam int DEPTH = 1 << INDEX_BITS;
  localparam int NW    = $clog2(INDEX_BITS + 1);

  // Counter table, no reset: cleared by the sweep
  logic [gbp_pkg::CTR_W-1:0] ctr_mem [DEPTH];

  logic [INDEX_BITS-1:0]       clr_idx_r;
  logic [INDEX_BITS-1:0]       idx_r;
  logic                        taken_r;
  logic [gbp_pkg::CTR_W-1:0]   rd_ctr_r;
  logic [INDEX_BITS-1:0]       hist_r;
  logic [gbp_pkg::CNT_W-1:0]   miss_r, miss_nxt;
  logic [gbp_pkg::CNT_W-1:0]   branch_r, branch_nxt;
  logic                        out_valid_r;
  gbp_pkg::out_word_t          out_data_r;

  logic [NW-1:0]               hist_len;
  logic [INDEX_BITS:0]         one_sh;
  logic [INDEX_BITS-1:0]       hmask;
  logic [INDEX_BITS-1:0]       hist_used;
  logic [INDEX_BITS-1:0]       idx_now;
  logic [INDEX_BITS-1:0]       top_bit;
  logic [INDEX_BITS-1:0]       hist_nxt;
  logic                        pred;
  logic                        miss;
  logic [gbp_pkg::CTR_W-1:0]   ctr_new;

  // Effective history length, capped at the index width
  always_comb begin
    if (32'(hist_bits) > INDEX_BITS) begin
      hist_len = NW'(INDEX_BITS);
    end else begin
      hist_len = NW'(hist_bits);
    end
  end

  // History mask and hashed index
  assign one_sh    = (INDEX_BITS + 1)'(1) << hist_len;
  assign hmask     = INDEX_BITS'(one_sh - 1'b1);
  assign hist_used = hist_r & hmask;
  assign idx_now   = in_data.branch_address[INDEX_BITS+1:2]
                   ^ (hist_used << (NW'(INDEX_BITS) - hist_len));

  // Prediction and counter step
  assign pred = rd_ctr_r[1];
  assign miss = pred ^ taken_r;

  always_comb begin
    ctr_new = rd_ctr_r;
    if (taken_r) begin
      if (rd_ctr_r != 2'd3) ctr_new = rd_ctr_r + 1'b1;
    end else begin
      if (rd_ctr_r != 2'd0) ctr_new = rd_ctr_r - 1'b1;
    end
  end

  // History shift: newest outcome enters at the top of the used bits
  always_comb begin
    top_bit  = '0;
    hist_nxt = hist_r;
    if (hist_len != '0) begin
      top_bit  = INDEX_BITS'(taken_r) << (hist_len - 1'b1);
      hist_nxt = ((hist_used >> 1) | top_bit) & hmask;
    end
  end

  // Saturating totals
  always_comb begin
    miss_nxt   = miss_r;
    branch_nxt = branch_r;
    if (miss && (miss_r != gbp_pkg::CNT_MAX)) miss_nxt = miss_r + 1'b1;
    if (branch_r != gbp_pkg::CNT_MAX) branch_nxt = branch_r + 1'b1;
  end

  // Table port: sweep or update write, registered read
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      ctr_mem[clr_idx_r] <= gbp_pkg::CTR_RESET;
    end else if (cmd.upd_en) begin
      ctr_mem[idx_r] <= ctr_new;
    end
    if (cmd.rd_en) begin
      rd_ctr_r <= ctr_mem[idx_now];
    end
  end

  // Captured branch word
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      idx_r   <= idx_now;
      taken_r <= in_data.taken;
    end
  end

  // Sweep pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_en) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  // History and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r   <= '0;
      miss_r   <= '0;
      branch_r <= '0;
    end else if (cmd.upd_en) begin
      hist_r   <= hist_nxt;
      miss_r   <= miss_nxt;
      branch_r <= branch_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.upd_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_en) begin
      out_data_r.predicted_taken <= pred;
      out_data_r.mispredicted    <= miss;
      out_data_r.miss_total      <= miss_nxt;
      out_data_r.branch_total    <= branch_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign stat.clr_last = &clr_idx_r;
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

FILE: src/gshare_branch_predictor_unit.sv
// Top level of the gshare branch predictor: channels, register port, controller, datapath.
`timescale 1ns / 1ps
//
// Usage
//   in_chan  : branch words (branch_address, taken), valid/ready.
//   out_chan : result words (predicted_taken, mispredicted, miss_total,
//              branch_total), valid/ready, one per branch word.
//   APB port : one register at byte address 0, history_bits [3:0], reset 8.
//              Write it only while no branch is in flight.
// Reset
//   rst_n low clears history and totals. Afterwards the counter table is
//   swept to weakly taken, one entry a cycle, all 2**INDEX_BITS entries (4096 at
//   the default), with in_chan.ready low. Register writes are taken as ever.
// Timing
//   A branch is accepted with the table read at that edge; once the result
//   register is free, a later edge does the counter read-modify-write and
//   loads the result register, which raises out_chan.valid. The registered
//   table read and its write-back mean no new branch is taken until that update.
// Stall
//   A waiting result holds in its register while the next branch is taken
//   and read; that branch's update waits until the result register frees.
//
module gshare_branch_predictor_unit #(
  parameter int INDEX_BITS = gbp_pkg::INDEX_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  gbp_in_if.sink                        in_chan,
  gbp_out_if.source                     out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gbp_pkg::CFG_AW-1:0]    paddr,
  input  logic [gbp_pkg::CFG_DW-1:0]    pwdata,
  output logic [gbp_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  logic [gbp_pkg::HIST_CFG_W-1:0] hist_bits_r;
  gbp_pkg::ctrl_cmd_t             cmd;
  gbp_pkg::dp_stat_t              stat;
  logic                           cfg_wr;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == gbp_pkg::REG_HISTORY_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_bits_r <= gbp_pkg::HIST_RESET;
    end else if (cfg_wr) begin
      hist_bits_r <= pwdata[gbp_pkg::HIST_CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == gbp_pkg::REG_HISTORY_BITS) begin
      prdata = gbp_pkg::CFG_DW'(hist_bits_r);
    end
  end

  // Controller
  gbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath
  gbp_dp #(
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .hist_bits (hist_bits_r),
    .in_data   (in_chan.data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_chan.data)
  );

endmodule

FILE: src/gbp_chk.sv
// Port-level checks of the gshare branch predictor, bound to the top level.
`timescale 1ns / 1ps

module gbp_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gbp_pkg::CNT_W-1:0]   miss_total,
  input logic [gbp_pkg::CNT_W-1:0]   branch_total
);

  // Table sweep keeps the input closed right after reset
  a_sweep_after_reset: assert property (@(posedge clk)
    disable iff (!rst_n) !$past(rst_n) |-> !in_ready)
    else $error("input open during table sweep");

  // One branch at a time: no acceptance on the edge after one
  a_one_in_flight: assert property (@(posedge clk)
    disable iff (!rst_n) (in_valid && in_ready) |=> !in_ready)
    else $error("branch accepted while previous one in update");

  // Misses never exceed branches
  a_miss_le_branch: assert property (@(posedge clk)
    disable iff (!rst_n) out_valid |-> (miss_total <= branch_total))
    else $error("miss total above branch total");

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk)
    disable iff (!rst_n) (out_valid && !out_ready) |=> out_valid)
    else $error("result word dropped under stall");

endmodule

bind gshare_branch_predictor_unit gbp_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .miss_total   (out_chan.data.miss_total),
  .branch_total (out_chan.data.branch_total)
);

FILE: test/tb_gshare_branch_predictor_unit.sv
// Self-checking testbench for the gshare branch predictor unit.
`timescale 1ns / 1ps

module tb_gshare_branch_predictor_unit;

  localparam int TABLE_SIZE  = 1 << gbp_pkg::INDEX_BITS;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 134;
  localparam int POOL        = 8;
  localparam int DRAIN_CYC   = 8;
  localparam logic [gbp_pkg::CFG_AW-1:0] HIST_ADDR = {gbp_pkg::REG_HISTORY_BITS, 2'b00};

  // Gshare model and queue of expected result words
  class gshare_scoreboard;
    logic [gbp_pkg::CTR_W-1:0]      ctr_tab [TABLE_SIZE];
    logic [gbp_pkg::INDEX_BITS-1:0] ghist;
    logic [gbp_pkg::CNT_W-1:0]      misses;
    logic [gbp_pkg::CNT_W-1:0]      branches;
    logic [gbp_pkg::HIST_CFG_W-1:0] hist_len;
    gbp_pkg::out_word_t             exp_q[$];
    int unsigned                    fails;

    function new();
      foreach (ctr_tab[i]) ctr_tab[i] = gbp_pkg::CTR_RESET;
      ghist    = '0;
      misses   = '0;
      branches = '0;
      hist_len = gbp_pkg::HIST_RESET;
      fails    = 0;
    endfunction

    function void set_hist_len(logic [gbp_pkg::HIST_CFG_W-1:0] v);
      hist_len = v;
    endfunction

    function int pending();
      return exp_q.size();
    endfunction

    // Predict and update for one accepted branch word
    function void note_branch(gbp_pkg::in_word_t w);
      int unsigned                    n;
      logic [gbp_pkg::INDEX_BITS-1:0] hmask;
      logic [gbp_pkg::INDEX_BITS-1:0] hist;
      logic [gbp_pkg::INDEX_BITS-1:0] idx;
      logic [gbp_pkg::INDEX_BITS-1:0] tkn;
      logic [gbp_pkg::CTR_W-1:0]      c;
      gbp_pkg::out_word_t             e;
      // lengths beyond the table index act as the full index
      n     = (hist_len > gbp_pkg::INDEX_BITS) ? gbp_pkg::INDEX_BITS : hist_len;
      hmask = (n == 0) ? '0 : gbp_pkg::INDEX_BITS'((1 << n) - 1);
      hist  = ghist & hmask;
      idx   = w.branch_address[gbp_pkg::INDEX_BITS+1:2]
            ^ (hist << (gbp_pkg::INDEX_BITS - n));
      c     = ctr_tab[idx];
      e.predicted_taken = c[1];
      e.mispredicted    = c[1] ^ w.taken;
      // saturating 2-bit counter
      if (w.taken) begin
        if (c != 2'd3) c = c + 2'd1;
      end else begin
        if (c != 2'd0) c = c - 2'd1;
      end
      ctr_tab[idx] = c;
      // newest outcome enters at the top of the active history
      if (n != 0) begin
        tkn   = gbp_pkg::INDEX_BITS'(w.taken);
        ghist = ((hist >> 1) | (tkn << (n - 1))) & hmask;
      end
      if (e.mispredicted && misses != gbp_pkg::CNT_MAX) misses = misses + 1;
      if (branches != gbp_pkg::CNT_MAX) branches = branches + 1;
      e.miss_total   = misses;
      e.branch_total = branches;
      exp_q = {exp_q, e};
    endfunction

    // Compare one result word with the oldest expectation
    function void check_result(gbp_pkg::out_word_t got);
      gbp_pkg::out_word_t e;
      if (exp_q.size() == 0) begin
        $error("result word with no branch outstanding: %h", got);
        fails++;
        return;
      end
      e = exp_q.pop_front();
      if (got.predicted_taken !== e.predicted_taken) begin
        $error("predicted_taken: expected %0d, got %0d", e.predicted_taken, got.predicted_taken);
        fails++;
      end
      if (got.mispredicted !== e.mispredicted) begin
        $error("mispredicted: expected %0d, got %0d", e.mispredicted, got.mispredicted);
        fails++;
      end
      if (got.miss_total !== e.miss_total) begin
        $error("miss_total: expected %0d, got %0d", e.miss_total, got.miss_total);
        fails++;
      end
      if (got.branch_total !== e.branch_total) begin
        $error("branch_total: expected %0d, got %0d", e.branch_total, got.branch_total);
        fails++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [gbp_pkg::CFG_AW-1:0] paddr;
  logic [gbp_pkg::CFG_DW-1:0] pwdata;
  logic [gbp_pkg::CFG_DW-1:0] prdata;
  logic                       pready;

  gbp_in_if  in_ch ();
  gbp_out_if out_ch ();

  gshare_scoreboard sb;
  int unsigned      tx_max;
  int unsigned      rx_max;

  // Loop-branch pool: each branch is taken trip times, then falls through once
  logic [gbp_pkg::ADDR_W-1:0] loop_addr [POOL];
  int unsigned                trip [POOL];
  int unsigned                iter [POOL];

  gshare_branch_predictor_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Accepted branch words feed the model
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_branch(in_ch.data);
  end

  // Accepted result words are checked
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // Result side: random stall before each word
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, rx_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Send one branch word after a gap; valid stays high into the next word
  task automatic send_branch(input logic [gbp_pkg::ADDR_W-1:0] addr, input logic tk);
    int unsigned       gap;
    gbp_pkg::in_word_t w;
    gap = $urandom_range(0, tx_max);
    w.branch_address = addr;
    w.taken          = tk;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Wait until every result word is back and the pipeline is quiet
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // APB write of history_bits, then read back
  task automatic set_history_bits(input logic [gbp_pkg::HIST_CFG_W-1:0] v);
    logic [gbp_pkg::CFG_DW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HIST_ADDR;
    pwdata  <= {$urandom} & ~gbp_pkg::CFG_DW'(4'hF) | gbp_pkg::CFG_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_hist_len(v);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[gbp_pkg::HIST_CFG_W-1:0] !== v) begin
      $error("history_bits: expected %0d, got %0d", v, rd[gbp_pkg::HIST_CFG_W-1:0]);
      sb.fails++;
    end
  endtask

  // Stimulus
  initial begin
    logic [gbp_pkg::HIST_CFG_W-1:0] hsel [PHASES];
    logic [gbp_pkg::ADDR_W-1:0]     base;
    int unsigned                    k;

    sb          = new();
    tx_max      = 13;
    rx_max      = 13;
    rst_n       <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No history: counter saturation and address aliasing on entry 0
    set_history_bits(4'd0);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'h0000_0003, 1'b0);
    send_branch(32'hFFFF_C000, 1'b0);
    send_branch(32'h0000_0002, 1'b0);
    send_branch(32'h0000_0001, 1'b0);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'h0000_3FFC, 1'b0);
    send_branch(32'hAAAA_AAAA, 1'b1);
    send_branch(32'h5555_5555, 1'b0);
    drain();

    // Full history, then oversized length; history kept across the change
    set_history_bits(4'd12);
    for (int i = 0; i < 6; i++) send_branch(32'h0000_1234, i[0]);
    drain();
    set_history_bits(4'd15);
    for (int i = 0; i < 6; i++) send_branch(32'hFFFF_1234, ~i[1]);
    drain();

    // Random phases, extremes and oversized lengths among them
    hsel = '{4'd8, 4'd0, 4'd12, 4'd1, 4'd15, 4'd13, 4'd14, 4'd5,
             4'd3, 4'd11, 4'd0, 4'd0};
    hsel[10] = 4'($urandom_range(0, 15));
    hsel[11] = 4'($urandom_range(0, 15));
    for (int p = 0; p < PHASES; p++) begin
      set_history_bits(hsel[p]);
      tx_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
      rx_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
      base   = $urandom;
      for (int j = 0; j < POOL; j++) begin
        loop_addr[j] = base + ($urandom_range(0, 255) << 2) + $urandom_range(0, 3);
        trip[j]      = $urandom_range(1, 7);
        iter[j]      = 0;
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(0, 3) != 0) begin
          k = $urandom_range(0, POOL - 1);
          send_branch(loop_addr[k], iter[k] < trip[k]);
          iter[k] = (iter[k] >= trip[k]) ? 0 : iter[k] + 1;
        end else begin
          send_branch($urandom, 1'($urandom_range(0, 1)));
        end
      end
      drain();
    end

    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
